>>> rtl/matrix_keypad_scanner_assert.svh
// ---------------------------------------------------------------------------
// Keypad scanner assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_SCANNER_ASSERT_SVH
`define MATRIX_KEYPAD_SCANNER_ASSERT_SVH

`ifndef SYNTH
// check prop on every rising clk edge outside reset
`define MKS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("keypad scanner check failed");
// check prop on every rising clk edge, reset included
`define MKS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("keypad scanner check failed");
`else
`define MKS_ASSERT(lbl, clk, rstn, prop)
`define MKS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/mks_pkg.sv
// ---------------------------------------------------------------------------
// Keypad scanner package
// Shared types, register indexes, reset values and the key layout.
// ---------------------------------------------------------------------------
`default_nettype none

package mks_pkg;

  localparam int unsigned KpN     = 4;
  localparam int unsigned CfgW    = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgNum  = 3;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_SETTLE   = 2'd1,
    REG_RELEASE  = 2'd2
  } cfg_reg_e;

  localparam logic [CfgW-1:0] DebounceRst = 20'd20000;
  localparam logic [CfgW-1:0] SettleRst   = 20'd5;
  localparam logic [CfgW-1:0] ReleaseRst  = 20'd10000;

  localparam logic [3:0] ColsIdle = 4'hF;

  // scanner phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_DEBOUNCE = 6'b000010,
    PH_SETTLE   = 6'b000100,
    PH_COLREAD  = 6'b001000,
    PH_RELEASE  = 6'b010000,
    PH_POST     = 6'b100000
  } phase_e;

  // row pattern with only row r driven low
  function automatic logic [3:0] row_low_mask(input logic [1:0] r);
    row_low_mask = ~(4'b0001 << r);
  endfunction

  // fixed layout 123A / 456B / 789C / *0#D
  function automatic logic [6:0] key_ascii(input logic [1:0] r, input logic [1:0] c);
    logic [6:0] k;
    unique case ({r, c})
      4'h0: k = 7'h31;
      4'h1: k = 7'h32;
      4'h2: k = 7'h33;
      4'h3: k = 7'h41;
      4'h4: k = 7'h34;
      4'h5: k = 7'h35;
      4'h6: k = 7'h36;
      4'h7: k = 7'h42;
      4'h8: k = 7'h37;
      4'h9: k = 7'h38;
      4'hA: k = 7'h39;
      4'hB: k = 7'h43;
      4'hC: k = 7'h2A;
      4'hD: k = 7'h30;
      4'hE: k = 7'h23;
      default: k = 7'h44;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mks_cfg_regs.sv
// ---------------------------------------------------------------------------
// Keypad scanner configuration registers
// Holds the three wait lengths and gives their timer load values,
// clamped to the timer range.
// ---------------------------------------------------------------------------
`default_nettype none

module mks_cfg_regs
  import mks_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 20
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]               cfg_index_i,
  input  wire logic [CfgW-1:0]                  cfg_data_i,
  output logic [CfgNum-1:0][TIMER_BITS-1:0]     load_o
);

  localparam int unsigned LdW = (TIMER_BITS > CfgW) ? TIMER_BITS : CfgW;
  localparam logic [LdW-1:0] TMax = LdW'((64'd1 << TIMER_BITS) - 64'd1);

  logic [CfgNum-1:0][CfgW-1:0] cfg_q;
  logic [CfgNum-1:0][LdW-1:0]  cfg_ext;

  assign cfg_ready_o = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_DEBOUNCE] <= DebounceRst;
      cfg_q[REG_SETTLE]   <= SettleRst;
      cfg_q[REG_RELEASE]  <= ReleaseRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE: cfg_q[REG_DEBOUNCE] <= cfg_data_i;
        REG_SETTLE:   cfg_q[REG_SETTLE]   <= cfg_data_i;
        REG_RELEASE:  cfg_q[REG_RELEASE]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp each wait to the largest timer value
  always_comb begin
    for (int i = 0; i < int'(CfgNum); i++) begin
      cfg_ext[i] = LdW'(cfg_q[i]);
      load_o[i]  = (cfg_ext[i] > TMax) ? TMax[TIMER_BITS-1:0]
                                        : cfg_ext[i][TIMER_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/matrix_keypad_scanner.sv
// ---------------------------------------------------------------------------
// 4x4 matrix keypad scanner
// Debounces a press, scans the rows, waits for release and reports the key.
// ---------------------------------------------------------------------------
// Usage: send one word per tick holding the sampled column levels; each word
// returns one result word with the row drive for the next tick and, on the
// report tick, the key's ASCII code, row and column (tuser high). A word is
// taken on every clock cycle while results are drained; the result appears
// in the cycle after its input word is accepted, held in a single output
// register, and the input side stalls only while that register is full and
// not taken. Wait lengths come from the configuration port and are clamped
// to the TIMER_BITS wide tick counter.
`default_nettype none

module matrix_keypad_scanner
  import mks_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 20
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgW-1:0]      cfg_data_i,
  // column samples
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [3:0] col_levels, [7:4] zero
  // results
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [15:0]               m_axis_tdata,   // [3:0] row_drive, [10:4] key_code,
                                                    // [12:11] key_row, [14:13] key_col
  output logic                      m_axis_tuser    // [0] key_valid
);

  logic [CfgNum-1:0][TIMER_BITS-1:0] load;

  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [1:0]            scan_q, scan_d;
  logic [1:0]            frow_q, frow_d;
  logic [1:0]            fcol_q, fcol_d;

  logic                  out_valid_q;
  logic [15:0]           out_data_q;
  logic                  out_user_q;

  logic                  in_hs;
  logic [3:0]            cols;
  logic                  any_low;
  logic                  col_hit;
  logic [1:0]            low_col;
  logic                  tmr_zero;
  logic [TIMER_BITS-1:0] tmr_dec;

  logic [3:0]            drive;
  logic                  kvalid;
  logic [6:0]            kcode;
  logic [1:0]            krow;
  logic [1:0]            kcol;

  mks_cfg_regs #(
    .TIMER_BITS (TIMER_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .load_o      (load)
  );

  // handshake: take a word whenever the output register can move on
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_hs         = s_axis_tvalid && s_axis_tready;

  assign cols     = s_axis_tdata[3:0];
  assign any_low  = (cols != ColsIdle);
  assign tmr_zero = (timer_q == '0);
  assign tmr_dec  = timer_q - {{(TIMER_BITS-1){1'b0}}, 1'b1};

  // lowest low column
  always_comb begin
    col_hit = 1'b0;
    low_col = 2'd0;
    for (int c = KpN - 1; c >= 0; c--) begin
      if (!cols[c]) begin
        col_hit = 1'b1;
        low_col = 2'(c);
      end
    end
  end

  // scan sequencer
  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    scan_d  = scan_q;
    frow_d  = frow_q;
    fcol_d  = fcol_q;
    drive   = 4'h0;
    kvalid  = 1'b0;
    kcode   = 7'h00;
    krow    = 2'd0;
    kcol    = 2'd0;
    unique case (phase_q)
      PH_DEBOUNCE: begin
        if (!tmr_zero) begin
          timer_d = tmr_dec;
        end else if (!any_low) begin
          phase_d = PH_IDLE;
        end else begin
          scan_d  = 2'd0;
          timer_d = load[REG_SETTLE];
          phase_d = PH_SETTLE;
          drive   = row_low_mask(2'd0);
        end
      end
      PH_SETTLE: begin
        if (!tmr_zero) begin
          timer_d = tmr_dec;
          drive   = row_low_mask(scan_q);
        end else if (any_low) begin
          frow_d  = scan_q;
          phase_d = PH_COLREAD;
        end else if (scan_q == 2'(KpN - 1)) begin
          // no row showed a press: phantom
          scan_d  = 2'd0;
          phase_d = PH_IDLE;
        end else begin
          scan_d  = scan_q + 2'd1;
          timer_d = load[REG_SETTLE];
          drive   = row_low_mask(scan_q + 2'd1);
        end
      end
      PH_COLREAD: begin
        phase_d = col_hit ? PH_RELEASE : PH_IDLE;
        if (col_hit) begin
          fcol_d = low_col;
        end
      end
      PH_RELEASE: begin
        if (!any_low) begin
          timer_d = load[REG_RELEASE];
          phase_d = PH_POST;
        end
      end
      PH_POST: begin
        if (!tmr_zero) begin
          timer_d = tmr_dec;
        end else begin
          kvalid  = 1'b1;
          krow    = frow_q;
          kcol    = fcol_q;
          kcode   = key_ascii(frow_q, fcol_q);
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (any_low) begin
          timer_d = load[REG_DEBOUNCE];
          phase_d = PH_DEBOUNCE;
        end
      end
    endcase
  end

  // state advances once per accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      scan_q  <= 2'd0;
      frow_q  <= 2'd0;
      fcol_q  <= 2'd0;
    end else if (in_hs) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      scan_q  <= scan_d;
      frow_q  <= frow_d;
      fcol_q  <= fcol_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_hs) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      out_data_q <= {1'b0, kcol, krow, kcode, drive};
      out_user_q <= kvalid;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // checks
  `include "matrix_keypad_scanner_assert.svh"

  // row drive is either all rows low or exactly one row low
  `MKS_ASSERT(a_drive_shape, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[3:0] == 4'h0 || $countones(m_axis_tdata[3:0]) == 3))
  `MKS_ASSERT(a_report_rows_low, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[3:0] == 4'h0 && m_axis_tdata[10:4] != 7'h00))
  `MKS_ASSERT(a_quiet_fields, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[15:4] == 12'h000))
  `MKS_ASSERT_ALWAYS(a_ready_when_empty, clk_i, !m_axis_tvalid |-> s_axis_tready)

endmodule

`default_nettype wire
